[rtl/core/dsw_pkg.sv]
// dsw_pkg: shared types, constants and the digit font for the decimal seven-segment writer
// no dependencies; used by dsw_bcd and decimal_seven_segment_writer_top
package dsw_pkg;

   localparam int BIN_W      = 32;                 // magnitude width
   localparam int BCD_DIGITS = 10;                 // decimal digits of a 32-bit magnitude
   localparam int BCD_W      = 4 * BCD_DIGITS;
   localparam int CNT_W      = $clog2(BIN_W + 1);  // conversion step counter
   localparam int POS_W      = 4;                  // digit position width

   localparam logic [7:0] ADDR_BASE     = 8'hC0;
   localparam logic [7:0] MINUS_PATTERN = 8'h40;
   localparam logic [7:0] DP_BIT        = 8'h08;
   localparam logic [3:0] SIGN_POS_RST  = 4'd5;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SIGN,
      ST_DIGITS
   } state_type;

   typedef struct packed {
      logic start;       // load a new magnitude and begin conversion
      logic next_digit;  // drop the lowest bcd digit
   } bcd_ctrl_type;

   typedef struct packed {
      logic       busy;       // conversion in progress
      logic [3:0] digit;      // lowest remaining bcd digit
      logic       rest_zero;  // all digits above the lowest are zero
   } bcd_status_type;

   function automatic logic [7:0] digit_font(input logic [3:0] d);
      logic [7:0] seg;
      unique case (d)
         4'd0:    seg = 8'b10110111;
         4'd1:    seg = 8'b00000011;
         4'd2:    seg = 8'b11010110;
         4'd3:    seg = 8'b11000111;
         4'd4:    seg = 8'b01100011;
         4'd5:    seg = 8'b11100101;
         4'd6:    seg = 8'b11110101;
         4'd7:    seg = 8'b10000011;
         4'd8:    seg = 8'b11110111;
         4'd9:    seg = 8'b11100111;
         default: seg = 8'h00;
      endcase
      return seg;
   endfunction

endpackage

[rtl/core/dsw_bcd.sv]
// dsw_bcd: bit-serial double-dabble binary to bcd converter with digit shift-out
// depends on dsw_pkg
module dsw_bcd (
   input  logic                           clock,
   input  logic                           reset,
   input  dsw_pkg::bcd_ctrl_type          ctrl,
   input  logic [dsw_pkg::BIN_W-1:0]      magnitude,
   output dsw_pkg::bcd_status_type        status
);

   logic [dsw_pkg::BIN_W-1:0] bin_ff, bin_in;
   logic [dsw_pkg::BCD_W-1:0] bcd_ff, bcd_in;
   logic [dsw_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [dsw_pkg::BCD_W-1:0] adj;

   // add-3 correction on every digit, all independent
   always_comb begin
      adj = bcd_ff;
      for (int i = 0; i < dsw_pkg::BCD_DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end
      end
   end

   always_comb begin
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      cnt_in = cnt_ff;
      if (ctrl.start) begin
         bin_in = magnitude;
         bcd_in = '0;
         cnt_in = dsw_pkg::CNT_W'(dsw_pkg::BIN_W);
      end else if (cnt_ff != '0) begin
         {bcd_in, bin_in} = {adj[dsw_pkg::BCD_W-2:0], bin_ff, 1'b0};
         cnt_in = cnt_ff - 1'b1;
      end else if (ctrl.next_digit) begin
         bcd_in = {4'd0, bcd_ff[dsw_pkg::BCD_W-1:4]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign status.busy      = (cnt_ff != '0);
   assign status.digit     = bcd_ff[3:0];
   assign status.rest_zero = (bcd_ff[dsw_pkg::BCD_W-1:4] == '0);

endmodule

[rtl/core/decimal_seven_segment_writer_top.sv]
// decimal_seven_segment_writer_top: turns a signed integer into display-ram writes
// depends on dsw_pkg and dsw_bcd
// an accepted item goes through 32 conversion steps before its first write
// one item at a time: a new item is taken only once its last write is loaded (at most 11 writes)
// the bit-serial double-dabble converter sets the conversion time, one bit per cycle
// writes leave through one output register, one per cycle while rsp_ready is high
// reset: synchronous, active high; control idle, output empty, sign position back to 5
module decimal_seven_segment_writer_top #(
   parameter int MAX_DIGITS = 10
) (
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic signed [31:0] req_value,
   input  logic [3:0]  req_dp_position,
   // result items
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_address,
   output logic [7:0]  rsp_segments,
   output logic        rsp_last,
   // sign position register
   input  logic        csr_wr_en,
   input  logic [3:0]  csr_wr_data
);

   localparam logic [dsw_pkg::POS_W-1:0] LAST_POS = dsw_pkg::POS_W'(MAX_DIGITS - 1);

   dsw_pkg::state_type       state_ff, state_in;
   dsw_pkg::bcd_ctrl_type    bcd_ctrl;
   dsw_pkg::bcd_status_type  bcd_status;

   logic [3:0]               sign_pos_ff;
   logic                     mode_ff, mode_in;
   logic [3:0]               dp_ff, dp_in;
   logic                     neg_ff, neg_in;
   logic [dsw_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [dsw_pkg::BIN_W-1:0] magnitude;

   // output register
   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_addr_ff, out_addr_in;
   logic [7:0]  out_seg_ff, out_seg_in;
   logic        out_last_ff, out_last_in;

   logic        accept;
   logic        slot_free;
   logic        load;
   logic        digit_last;
   logic [7:0]  digit_seg;

   assign req_ready = (state_ff == dsw_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   // output slot can take a new write when empty or being emptied this cycle
   assign slot_free = !out_valid_ff || rsp_ready;

   // two's complement magnitude, most negative value wraps to 2^31 as unsigned
   assign magnitude = req_value[31] ? (32'd0 - 32'(req_value)) : 32'(req_value);

   assign digit_last = bcd_status.rest_zero || (pos_ff == LAST_POS);
   assign digit_seg  = dsw_pkg::digit_font(bcd_status.digit)
                     | ((mode_ff && (pos_ff == dp_ff)) ? dsw_pkg::DP_BIT : 8'h00);

   dsw_bcd u_bcd (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (bcd_ctrl),
      .magnitude (magnitude),
      .status    (bcd_status)
   );

   // sequencer
   always_comb begin
      state_in            = state_ff;
      mode_in             = mode_ff;
      dp_in               = dp_ff;
      neg_in              = neg_ff;
      pos_in              = pos_ff;
      bcd_ctrl.start      = 1'b0;
      bcd_ctrl.next_digit = 1'b0;
      load                = 1'b0;
      out_addr_in         = out_addr_ff;
      out_seg_in          = out_seg_ff;
      out_last_in         = out_last_ff;
      unique case (state_ff)
         dsw_pkg::ST_IDLE: begin
            if (accept) begin
               mode_in        = req_mode;
               dp_in          = req_dp_position;
               neg_in         = req_value[31];
               pos_in         = '0;
               bcd_ctrl.start = 1'b1;
               state_in       = dsw_pkg::ST_CONVERT;
            end
         end
         dsw_pkg::ST_CONVERT: begin
            if (!bcd_status.busy) begin
               state_in = neg_ff ? dsw_pkg::ST_SIGN : dsw_pkg::ST_DIGITS;
            end
         end
         dsw_pkg::ST_SIGN: begin
            // minus sign goes out first, even where a digit lands on the same place
            if (slot_free) begin
               load        = 1'b1;
               out_addr_in = dsw_pkg::ADDR_BASE + {3'd0, sign_pos_ff, 1'b0};
               out_seg_in  = dsw_pkg::MINUS_PATTERN;
               out_last_in = 1'b0;
               state_in    = dsw_pkg::ST_DIGITS;
            end
         end
         dsw_pkg::ST_DIGITS: begin
            // least significant digit first, stop at the top non-zero digit or at the last position
            if (slot_free) begin
               load                = 1'b1;
               out_addr_in         = dsw_pkg::ADDR_BASE + {3'd0, pos_ff, 1'b0};
               out_seg_in          = digit_seg;
               out_last_in         = digit_last;
               bcd_ctrl.next_digit = 1'b1;
               pos_in              = pos_ff + 1'b1;
               if (digit_last) begin
                  state_in = dsw_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = dsw_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dsw_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
         sign_pos_ff  <= dsw_pkg::SIGN_POS_RST;
         pos_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         pos_ff       <= pos_in;
         if (csr_wr_en) begin
            sign_pos_ff <= csr_wr_data;
         end
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      dp_ff       <= dp_in;
      neg_ff      <= neg_in;
      out_addr_ff <= out_addr_in;
      out_seg_ff  <= out_seg_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_address  = out_addr_ff;
   assign rsp_segments = out_seg_ff;
   assign rsp_last     = out_last_ff;

   // an accepted item always starts a conversion
   a_accept_converts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == dsw_pkg::ST_CONVERT) && bcd_status.busy)
      else $error("accepted item did not start conversion");

   // converter only runs while the sequencer waits for it
   a_busy_in_convert: assert property (@(posedge clock) disable iff (reset)
      bcd_status.busy |-> (state_ff == dsw_pkg::ST_CONVERT))
      else $error("converter busy outside conversion state");

   // sign write only for negative values
   a_sign_negative: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dsw_pkg::ST_SIGN) |-> neg_ff)
      else $error("sign write for a non-negative value");

   // digit position never runs past the digit limit
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dsw_pkg::ST_DIGITS) |-> (pos_ff <= LAST_POS))
      else $error("digit position beyond limit");

endmodule
